// File: hw/rtl/bmhq_pkg.sv
// bmhq_pkg: request and response types and codes for the binary min-heap queue
// no dependencies; imported by binary_min_heap_queue_unit
package bmhq_pkg;

  // request opcodes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // response status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // request payload
  typedef struct packed {
    logic        req_type;
    logic [31:0] key_value;
  } heap_req_t;

  // response payload
  typedef struct packed {
    logic [31:0] min_value;
    logic [6:0]  entry_count;
    logic [1:0]  status;
  } heap_rsp_t;

endpackage

// File: hw/rtl/binary_min_heap_queue_unit.sv
// Binary min-heap priority queue. A refused request or a remove that empties the queue goes
// straight to the response; an insert into an empty queue first writes the root, and other
// requests sift up or down as far as needed before the response. The heap memory is walked
// one level at a time (registered read, then compare and one write), so one request is handled
// at a time; in_ready is low while a sift runs and returns in the same cycle that the response
// goes valid. A stalled out_ready holds the finished response and delays the return of in_ready.
// Synchronous active-low reset clears the count, the key order and the handshake state; the
// heap memory is not cleared, since entries at or above the count are never read.
module binary_min_heap_queue_unit
  import bmhq_pkg::*;
#(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  heap_req_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output heap_rsp_t out_data,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CHD_W = IDX_W + 2;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_UP_RD   = 7'b0000010,
    ST_UP_CMP  = 7'b0000100,
    ST_DN_LAST = 7'b0001000,
    ST_DN_RD   = 7'b0010000,
    ST_DN_CMP  = 7'b0100000,
    ST_EMIT    = 7'b1000000
  } state_t;

  // strict less-than under the selected key order
  function automatic logic key_less(input logic [KEY_WIDTH-1:0] a,
                                    input logic [KEY_WIDTH-1:0] b,
                                    input logic                 sgn);
    logic [KEY_WIDTH-1:0] flip;
    flip = '0;
    flip[KEY_WIDTH-1] = sgn;
    return (a ^ flip) < (b ^ flip);
  endfunction

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 signed_keys_r;
  logic                 out_valid_r, out_valid_nxt;
  heap_rsp_t            out_data_r, out_data_nxt;
  logic [IDX_W-1:0]     pos_r, pos_nxt;
  logic [KEY_WIDTH-1:0] cur_r, cur_nxt;
  logic [KEY_WIDTH-1:0] root_r, root_nxt;
  logic [1:0]           status_r, status_nxt;

  // heap memory and its registered read ports
  logic [KEY_WIDTH-1:0] heap_mem_r [CAPACITY];
  logic [KEY_WIDTH-1:0] rd_a_r, rd_b_r;
  logic                 rd_a_en, rd_b_en, wr_en;
  logic [IDX_W-1:0]     rd_a_addr, rd_b_addr;
  logic [KEY_WIDTH-1:0] wr_data;

  // derived indexes and values
  logic [63:0]          key_ext;
  logic [KEY_WIDTH-1:0] key_in;
  logic [63:0]          root_ext;
  logic [CNT_W-1:0]     count_dec;
  logic [IDX_W-1:0]     parent_idx;
  logic [CHD_W-1:0]     left_w, right_w, limit_w;
  logic                 right_ok, pick_right;
  logic [KEY_WIDTH-1:0] pick_val;
  logic [IDX_W-1:0]     pick_idx;
  logic                 accept, out_free;

  assign key_ext    = 64'(in_data.key_value);
  assign key_in     = key_ext[KEY_WIDTH-1:0];
  assign root_ext   = 64'(root_r);
  assign count_dec  = count_r - CNT_W'(1);
  assign parent_idx = (pos_r - IDX_W'(1)) >> 1;
  assign left_w     = {1'b0, pos_r, 1'b1};
  assign right_w    = left_w + CHD_W'(1);
  assign limit_w    = CHD_W'(count_r);
  assign right_ok   = right_w < limit_w;
  assign pick_right = right_ok && !key_less(rd_a_r, rd_b_r, signed_keys_r);
  assign pick_val   = pick_right ? rd_b_r : rd_a_r;
  assign pick_idx   = pick_right ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    root_nxt      = root_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    rd_a_en       = 1'b0;
    rd_b_en       = 1'b0;
    rd_a_addr     = '0;
    rd_b_addr     = '0;
    wr_en         = 1'b0;
    wr_data       = cur_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          status_nxt = STATUS_OK;
          if (in_data.req_type == REQ_INSERT) begin
            if (count_r == CNT_W'(CAPACITY)) begin
              status_nxt = STATUS_FULL;
              state_nxt  = ST_EMIT;
            end else begin
              cur_nxt   = key_in;
              pos_nxt   = count_r[IDX_W-1:0];
              count_nxt = count_r + CNT_W'(1);
              state_nxt = ST_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = STATUS_EMPTY;
              state_nxt  = ST_EMIT;
            end else if (count_dec == '0) begin
              count_nxt = count_dec;
              state_nxt = ST_EMIT;
            end else begin
              count_nxt = count_dec;
              pos_nxt   = '0;
              rd_a_en   = 1'b1;
              rd_a_addr = count_dec[IDX_W-1:0];
              state_nxt = ST_DN_LAST;
            end
          end
        end
      end
      // sift up: fetch the parent or settle at the root
      ST_UP_RD: begin
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          wr_data   = cur_r;
          root_nxt  = cur_r;
          state_nxt = ST_EMIT;
        end else begin
          rd_a_en   = 1'b1;
          rd_a_addr = parent_idx;
          state_nxt = ST_UP_CMP;
        end
      end
      // sift up: move parent down into the hole or place the key
      ST_UP_CMP: begin
        wr_en = 1'b1;
        if (key_less(cur_r, rd_a_r, signed_keys_r)) begin
          wr_data   = rd_a_r;
          pos_nxt   = parent_idx;
          state_nxt = ST_UP_RD;
        end else begin
          wr_data   = cur_r;
          state_nxt = ST_EMIT;
        end
      end
      // sift down: last entry becomes the moving key
      ST_DN_LAST: begin
        cur_nxt   = rd_a_r;
        state_nxt = ST_DN_RD;
      end
      // sift down: fetch both children or settle at a leaf
      ST_DN_RD: begin
        if (left_w >= limit_w) begin
          wr_en   = 1'b1;
          wr_data = cur_r;
          if (pos_r == '0) begin
            root_nxt = cur_r;
          end
          state_nxt = ST_EMIT;
        end else begin
          rd_a_en   = 1'b1;
          rd_a_addr = left_w[IDX_W-1:0];
          rd_b_en   = right_ok;
          rd_b_addr = right_w[IDX_W-1:0];
          state_nxt = ST_DN_CMP;
        end
      end
      // sift down: pull the smaller child up or place the key
      ST_DN_CMP: begin
        wr_en = 1'b1;
        if (key_less(pick_val, cur_r, signed_keys_r)) begin
          wr_data   = pick_val;
          pos_nxt   = pick_idx;
          state_nxt = ST_DN_RD;
        end else begin
          wr_data   = cur_r;
          state_nxt = ST_EMIT;
        end
        if (pos_r == '0) begin
          root_nxt = wr_data;
        end
      end
      // hand the response to the output register
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.min_value   = (count_r != '0) ? root_ext[31:0] : 32'd0;
          out_data_nxt.entry_count = 7'(count_r);
          out_data_nxt.status      = status_r;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
      signed_keys_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        signed_keys_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    cur_r      <= cur_nxt;
    root_r     <= root_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  // heap memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem_r[pos_r] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_r <= heap_mem_r[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_r <= heap_mem_r[rd_b_addr];
    end
  end

`ifndef ASSERT_OFF
  // count never passes the capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // a refused insert leaves the count alone
  a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.req_type == REQ_INSERT && count_r == CNT_W'(CAPACITY))
      |=> (count_r == $past(count_r) && status_r == STATUS_FULL))
    else $error("refused insert changed the count");

  // the sift position stays inside the held entries
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && state_r != ST_EMIT) |-> (CNT_W'(pos_r) < count_r))
    else $error("sift position outside held entries");

  // a response carries the count left by its request
  a_rsp_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free)
      |=> (out_valid_r && out_data_r.entry_count == 7'(count_r)))
    else $error("response count mismatch");
`endif

endmodule
